// ===== hw/rtl/dttl_pkg.sv =====
package dttl_pkg;

  // Request kinds carried in s_tuser
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_SCHED   = 2'd1;
  localparam logic [1:0] REQ_UNSCHED = 2'd2;

  // Result status carried in m_tuser
  localparam logic [1:0] RES_FIRED = 2'd0;
  localparam logic [1:0] RES_DONE  = 2'd1;
  localparam logic [1:0] RES_FULL  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SPEED = 1'b0;
  localparam logic CFG_RUN   = 1'b1;

  localparam logic [15:0] SPEED_RESET = 16'd256;

  localparam int TIME_W  = 48;
  localparam int CLOCK_W = 56;
  localparam int DELAY_W = 32;
  localparam int ID_W    = 8;
  localparam int PROD_W  = 64;

  typedef struct packed {
    logic               started;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
    logic [CLOCK_W-1:0] start;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLK,
    S_MUL,
    S_ADD,
    S_PRIME,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic sched_wr;
    logic clk_init;
    logic clk_latch;
    logic diff;
    logic mul;
    logic add;
    logic scan_start;
    logic scan_step;
    logic emit_resp;
  } cmd_t;

  typedef struct packed {
    logic not_started;
    logic run;
    logic cnt_zero;
    logic scan_last;
    logic hit;
    logic is_tick;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/dttl_ram.sv =====
module dttl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/dttl_ctrl.sv =====
module dttl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_req,
  input  dttl_pkg::sts_t sts,
  output dttl_pkg::cmd_t cmd,
  output logic           in_ready
);
  import dttl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_req)
            REQ_TICK:    state_next = S_CLK;
            REQ_SCHED: begin
              cmd.sched_wr = 1'b1;
              state_next   = S_RESP;
            end
            REQ_UNSCHED: state_next = S_PRIME;
            default:     state_next = S_RESP;
          endcase
        end
      end
      S_CLK: begin
        if (sts.not_started) begin
          cmd.clk_init = 1'b1;
          state_next   = S_PRIME;
        end else if (sts.run) begin
          cmd.diff   = 1'b1;
          state_next = S_MUL;
        end else begin
          cmd.clk_latch = 1'b1;
          state_next    = S_PRIME;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_PRIME;
      end
      S_PRIME: begin
        if (sts.cnt_zero) begin
          state_next = S_RESP;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        // hold while a fired result has nowhere to go
        if (!(sts.hit && sts.is_tick && !sts.out_free)) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_next = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit_resp = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/dttl_dp.sv =====
module dttl_dp #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dttl_pkg::cmd_t            cmd,
  output dttl_pkg::sts_t            sts,
  input  logic [1:0]                in_req,
  input  logic [dttl_pkg::TIME_W-1:0]  in_time,
  input  logic [dttl_pkg::ID_W-1:0]    in_id,
  input  logic [dttl_pkg::DELAY_W-1:0] in_delay,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [dttl_pkg::ID_W-1:0]    out_id,
  output logic [dttl_pkg::CLOCK_W-1:0] out_now,
  output logic                      out_last
);
  import dttl_pkg::*;

  localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TASK_SLOTS);

  logic [15:0]        speed;
  logic               run_en;
  logic [1:0]         req;
  logic [ID_W-1:0]    req_id;
  logic [TIME_W-1:0]  tick_t;
  logic               resp_full;
  logic [CLOCK_W-1:0] clock;
  logic [TIME_W-1:0]  last_t;
  logic [TIME_W-1:0]  diff;
  logic [PROD_W-1:0]  prod;
  logic [CW-1:0]      cnt, rd, wr;

  slot_t              rd_slot, wr_slot;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;

  logic [CLOCK_W-1:0] eff_start, thresh;
  logic [CLOCK_W:0]   elapsed;
  logic [PROD_W:0]    sum;
  logic               hit, is_tick, out_free, full_now, fire;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed  <= SPEED_RESET;
      run_en <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SPEED) begin
        speed <= cfg_data;
      end
      if (cfg_index == CFG_RUN) begin
        run_en <= cfg_data[0];
      end
    end
  end

  // slot evaluation; a clock restarted below a start counts as overdue
  assign is_tick   = (req == REQ_TICK);
  assign eff_start = rd_slot.started ? rd_slot.start : clock;
  assign elapsed   = {1'b0, clock} - {1'b0, eff_start};
  assign thresh    = {{(CLOCK_W - DELAY_W - 8){1'b0}}, rd_slot.delay, 8'd0};
  assign hit       = is_tick ? (elapsed[CLOCK_W] || (elapsed[CLOCK_W-1:0] >= thresh))
                             : (rd_slot.id == req_id);
  assign out_free  = !out_valid || out_ready;
  assign full_now  = (cnt == FULL_CNT);
  assign fire      = cmd.scan_step && hit && is_tick;

  assign sum = {{(PROD_W - CLOCK_W + 1){1'b0}}, clock} + {1'b0, prod};

  always_comb begin
    sts             = '0;
    sts.not_started = (last_t == '0);
    sts.run         = run_en;
    sts.cnt_zero    = (cnt == '0);
    sts.scan_last   = (rd == cnt);
    sts.hit         = hit;
    sts.is_tick     = is_tick;
    sts.out_free    = out_free;
  end

  // slot store port control
  always_comb begin
    if (cmd.sched_wr) begin
      wr_slot.started = 1'b0;
      wr_slot.id      = in_id;
      wr_slot.delay   = in_delay;
      wr_slot.start   = '0;
      ram_waddr       = cnt[AW-1:0];
      ram_we          = !full_now;
    end else begin
      wr_slot.started = is_tick ? 1'b1 : rd_slot.started;
      wr_slot.id      = rd_slot.id;
      wr_slot.delay   = rd_slot.delay;
      wr_slot.start   = is_tick ? eff_start : rd_slot.start;
      ram_waddr       = wr[AW-1:0];
      ram_we          = cmd.scan_step && !hit;
    end
    ram_re    = cmd.scan_start || (cmd.scan_step && !sts.scan_last);
    ram_raddr = cmd.scan_start ? '0 : rd[AW-1:0];
  end

  dttl_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(TASK_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_slot),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_slot)
  );

  // request latch, clock update, scan pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock  <= '0;
      last_t <= '0;
      cnt    <= '0;
      rd     <= '0;
      wr     <= '0;
    end else begin
      if (cmd.sched_wr && !full_now) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.clk_init) begin
        last_t <= tick_t;
        clock  <= '0;
      end
      if (cmd.clk_latch) begin
        last_t <= tick_t;
      end
      if (cmd.add) begin
        last_t <= tick_t;
        clock  <= (sum[PROD_W:CLOCK_W] != '0) ? '1 : sum[CLOCK_W-1:0];
      end
      if (cmd.scan_start) begin
        rd <= CW'(1);
        wr <= '0;
      end
      if (cmd.scan_step) begin
        if (!hit) begin
          wr <= wr + 1'b1;
        end
        if (sts.scan_last) begin
          cnt <= hit ? wr : wr + 1'b1;
        end else begin
          rd <= rd + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req       <= in_req;
      req_id    <= in_id;
      tick_t    <= in_time;
      resp_full <= (in_req == REQ_SCHED) && full_now;
    end
    if (cmd.diff) begin
      diff <= (tick_t >= last_t) ? (tick_t - last_t) : '0;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(diff * speed);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire || cmd.emit_resp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= RES_FIRED;
      out_id     <= rd_slot.id;
      out_now    <= clock;
      out_last   <= 1'b0;
    end else if (cmd.emit_resp) begin
      out_status <= resp_full ? RES_FULL : RES_DONE;
      out_id     <= req_id;
      out_now    <= clock;
      out_last   <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/delayed_task_timer_list_unit.sv =====
// Timer list unit: tick, schedule and unschedule requests over one stream.
// Schedule and unknown kinds go straight to the done result; an unschedule scans the
// slots, and a tick updates the clock and then scans. A request is taken only after the
// previous one is done. The n slots in use are scanned one a cycle through the single
// read port, and a stalled fired result holds the scan.
// Reset (rst, synchronous): empty list, clock zero and not started, speed 256, run on.
module delayed_task_timer_list_unit #(
  parameter int TASK_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // tick_time[47:0], task_id[55:48], delay[87:56]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // fired_id[7:0], now_scaled[63:8]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import dttl_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [ID_W-1:0]    out_id;
  logic [CLOCK_W-1:0] out_now;

  // Controller: sequences the clock update, the compacting scan and the
  // final response; accepts a request only when the previous one is done.
  dttl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_req   (s_tuser),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  // Datapath: slot store, scaled clock, result register. The result
  // register parts the two sides, so a new request is taken while the
  // last result of the previous one still waits.
  dttl_dp #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (s_tuser),
    .in_time    (s_tdata[47:0]),
    .in_id      (s_tdata[55:48]),
    .in_delay   (s_tdata[87:56]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_id     (out_id),
    .out_now    (out_now),
    .out_last   (m_tlast)
  );

  assign m_tdata = {out_now, out_id};

endmodule

// ===== hw/rtl/dttl_checker.sv =====
module dttl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import dttl_pkg::*;

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a fired task never ends a request; every other result does
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == RES_FIRED) == !m_tlast))
    else $error("tlast does not match result status");

  // one request at a time: no transfer in the cycle after a transfer
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in progress");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind delayed_task_timer_list_unit dttl_checker u_dttl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/tb_delayed_task_timer_list_unit.sv =====
module tb_delayed_task_timer_list_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dttl_pkg::*;

  localparam int SLOTS = 16;
  // Worst gap between transfers: long sender gap, a full tick scan, a long
  // receiver stall, the settle pause. Take it several times over.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles to let pass after the last result before touching registers or
  // ending the run: a full tick scan plus margin.
  localparam int SETTLE = SLOTS + 10;
  localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  // Request kind the block does not know; it only answers with done.
  localparam logic [1:0] REQ_BOGUS = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    id;
    logic [CLOCK_W-1:0] now;
    logic               last;
  } result_t;

  typedef struct {
    logic [1:0]         req;
    logic [TIME_W-1:0]  t;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] dly;
    int                 reps;
    bit                 typed;
    logic [1:0]         want_status;
    logic [CLOCK_W-1:0] want_now;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_SPEED;
  logic [15:0] cfg_data = '0;

  delayed_task_timer_list_unit #(.TASK_SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Timer list mirror: scaled clock, latched wall time, ordered task slots.
  // ---------------------------------------------------------------------
  logic [15:0]        speed_cfg = SPEED_RESET;
  logic               run_cfg = 1'b1;
  logic [CLOCK_W-1:0] sc_clock = '0;
  logic [TIME_W-1:0]  tick_mark = '0;
  logic               lst_valid[SLOTS];
  logic               lst_started[SLOTS];
  logic [ID_W-1:0]    lst_id[SLOTS];
  logic [DELAY_W-1:0] lst_delay[SLOTS];
  logic [CLOCK_W-1:0] lst_start[SLOTS];

  result_t step_results[$];   // results of the request being mirrored
  result_t due_results[$];    // results still owed by the block, oldest first
  row_t    plan[$];

  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_fired = 0;
  int n_full = 0;
  bit jitter_on = 1'b1;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      lst_valid[i] = 1'b0;
      lst_started[i] = 1'b0;
    end
  end

  // Remove slot k and close the gap so the valid slots stay a prefix.
  task automatic drop_slot(input int k);
    for (int j = k; j < SLOTS - 1; j++) begin
      lst_valid[j] = lst_valid[j+1];
      lst_started[j] = lst_started[j+1];
      lst_id[j] = lst_id[j+1];
      lst_delay[j] = lst_delay[j+1];
      lst_start[j] = lst_start[j+1];
    end
    lst_valid[SLOTS-1] = 1'b0;
    lst_started[SLOTS-1] = 1'b0;
  endtask

  task automatic apply_request(input logic [1:0] req, input logic [TIME_W-1:0] t,
                               input logic [ID_W-1:0] id, input logic [DELAY_W-1:0] dly);
    int k;
    logic [63:0] diff;
    logic [63:0] inc;
    logic [63:0] room;
    logic [63:0] elapsed;
    step_results.delete();
    case (req)
      REQ_TICK: begin
        if (tick_mark == '0) begin
          // not started yet: latch the wall time, restart the clock
          tick_mark = t;
          sc_clock = '0;
        end else begin
          if (run_cfg) begin
            // time running backward counts as no time at all
            diff = (t >= tick_mark) ? {16'd0, t - tick_mark} : 64'd0;
            inc = diff * {48'd0, speed_cfg};
            room = {8'd0, CLOCK_MAX} - {8'd0, sc_clock};
            if (inc > room) sc_clock = CLOCK_MAX;
            else sc_clock = sc_clock + inc[CLOCK_W-1:0];
          end
          tick_mark = t;
        end
        k = 0;
        while (k < SLOTS && lst_valid[k]) begin
          if (!lst_started[k]) begin
            lst_start[k] = sc_clock;
            lst_started[k] = 1'b1;
          end
          // 64-bit difference: a restarted clock below a start wraps and fires
          elapsed = {8'd0, sc_clock} - {8'd0, lst_start[k]};
          if (elapsed >= {24'd0, lst_delay[k], 8'd0}) begin
            step_results.insert(step_results.size(),
                                result_t'{RES_FIRED, lst_id[k], sc_clock, 1'b0});
            drop_slot(k);
          end else begin
            k++;
          end
        end
        step_results.insert(step_results.size(), result_t'{RES_DONE, id, sc_clock, 1'b1});
      end
      REQ_SCHED: begin
        k = 0;
        while (k < SLOTS && lst_valid[k]) k++;
        if (k >= SLOTS) begin
          step_results.insert(step_results.size(), result_t'{RES_FULL, id, sc_clock, 1'b1});
        end else begin
          lst_valid[k] = 1'b1;
          lst_started[k] = 1'b0;
          lst_id[k] = id;
          lst_delay[k] = dly;
          step_results.insert(step_results.size(), result_t'{RES_DONE, id, sc_clock, 1'b1});
        end
      end
      REQ_UNSCHED: begin
        k = 0;
        while (k < SLOTS && lst_valid[k]) begin
          if (lst_id[k] == id) drop_slot(k);
          else k++;
        end
        step_results.insert(step_results.size(), result_t'{RES_DONE, id, sc_clock, 1'b1});
      end
      default: begin
        step_results.insert(step_results.size(), result_t'{RES_DONE, id, sc_clock, 1'b1});
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!jitter_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request, hold it until the transfer, then mirror it. A typed
  // expectation replaces the mirrored one; the mirror still updates its state.
  task automatic send_req(input logic [1:0] req, input logic [TIME_W-1:0] t,
                          input logic [ID_W-1:0] id, input logic [DELAY_W-1:0] dly,
                          input bit typed, input logic [1:0] want_status,
                          input logic [CLOCK_W-1:0] want_now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {dly, id, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_request(req, t, id, dly);
    if (typed) begin
      due_results.insert(due_results.size(), result_t'{want_status, id, want_now, 1'b1});
    end else begin
      foreach (step_results[i]) due_results.insert(due_results.size(), step_results[i]);
    end
    n_requests++;
  endtask

  // Drop valid, wait for every owed result, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; only call while drained.
  task automatic set_config(input logic [15:0] speed, input logic run);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SPEED;
    cfg_data <= speed;
    @(posedge clk);
    speed_cfg = speed;
    cfg_index <= CFG_RUN;
    cfg_data <= {15'd0, run};
    @(posedge clk);
    run_cfg = run;
    cfg_we <= 1'b0;
  endtask

  function automatic void add_row(input logic [1:0] req, input logic [TIME_W-1:0] t,
                                  input logic [ID_W-1:0] id, input logic [DELAY_W-1:0] dly,
                                  input int reps, input bit typed,
                                  input logic [1:0] want_status,
                                  input logic [CLOCK_W-1:0] want_now);
    row_t r;
    r.req = req;
    r.t = t;
    r.id = id;
    r.dly = dly;
    r.reps = reps;
    r.typed = typed;
    r.want_status = want_status;
    r.want_now = want_now;
    plan.insert(plan.size(), r);
  endfunction

  // Random requests: mostly schedules and forward ticks over a small id pool
  // so tasks really fire and get removed; the rest is noise.
  task automatic random_phase(input int count);
    int r;
    logic [63:0] wide;
    logic [1:0] req;
    logic [TIME_W-1:0] t;
    logic [ID_W-1:0] id;
    logic [DELAY_W-1:0] dly;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      wide = {$urandom(), $urandom()};
      t = wide[TIME_W-1:0];
      id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom()) : ID_W'($urandom_range(0, 7));
      dly = $urandom();
      if (r < 35) begin
        req = REQ_SCHED;
        r = $urandom_range(0, 9);
        if (r < 7) dly = $urandom_range(0, 40);
        else if (r < 9) dly = $urandom_range(0, 2000);
      end else if (r < 45) begin
        req = REQ_UNSCHED;
      end else if (r < 48) begin
        req = REQ_BOGUS;
      end else begin
        req = REQ_TICK;
        r = $urandom_range(0, 99);
        if (r < 5) begin
          t = '0;
        end else if (r < 13 && tick_mark > 1) begin
          t = t % tick_mark;
        end else if (r < 20 && !run_cfg) begin
          // full-range jump while frozen: only moves the latched time
        end else if (tick_mark == '0) begin
          t = $urandom_range(1, 5000);
        end else begin
          t = tick_mark + TIME_W'($urandom_range(0, 50));
        end
      end
      send_req(req, t, id, dly, 1'b0, RES_DONE, '0);
      // hold off now and then until the block has answered everything
      if ($urandom_range(0, 24) == 0) drain();
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------
  int ready_hold = 0;

  always @(posedge clk) begin
    if (!jitter_on) begin
      m_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          m_tready <= 1'b1;
          ready_hold <= $urandom_range(0, 12);
        end
        9: begin
          m_tready <= 1'b0;
          ready_hold <= $urandom_range(10, 30);
        end
        default: begin
          m_tready <= 1'b0;
          ready_hold <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Compare each result transfer with the oldest owed result.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (m_tuser == RES_FIRED) n_fired++;
      if (m_tuser == RES_FULL) n_full++;
      if (due_results.size() == 0) begin
        $error("result with nothing owed: status %0d id %0h", m_tuser, m_tdata[7:0]);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          errors++;
        end
        if (m_tdata[7:0] !== want.id) begin
          $error("fired_id: expected %0h, got %0h", want.id, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[63:8] !== want.now) begin
          $error("now_scaled: expected %0h, got %0h", want.now, m_tdata[63:8]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Stop a hung run: too long without any transfer or register write.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results owed",
                 WATCHDOG_LIMIT, due_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    // Directed rows at speed 256, running. Typed results are single done or
    // table-full replies; all ticks but the first go through the mirror.
    add_row(REQ_TICK,    '0,       8'h11, '0,    1, 1, RES_DONE, '0);  // zero before start
    add_row(REQ_SCHED,   '0,       8'hA5, '0,    1, 1, RES_DONE, '0);
    add_row(REQ_TICK,    48'd1000, 8'h00, '0,    1, 0, RES_DONE, '0);  // first real tick
    add_row(REQ_SCHED,   TIME_MAX, 8'h00, '1,    1, 1, RES_DONE, '0);  // longest delay
    add_row(REQ_SCHED,   '0,       8'hFF, 32'd1, 1, 1, RES_DONE, '0);
    add_row(REQ_TICK,    48'd1001, 8'h01, '0,    1, 0, RES_DONE, '0);
    add_row(REQ_TICK,    48'd1002, 8'h02, '0,    1, 0, RES_DONE, '0);
    add_row(REQ_TICK,    48'd500,  8'h03, '0,    1, 0, RES_DONE, '0);  // time backward
    add_row(REQ_SCHED,   '0,       8'h20, 32'd3, 7, 1, RES_DONE, 56'd512);
    add_row(REQ_SCHED,   '0,       8'h40, 32'd0, 7, 1, RES_DONE, 56'd512);
    add_row(REQ_SCHED,   '0,       8'h30, 32'd2, 1, 1, RES_DONE, 56'd512);
    add_row(REQ_SCHED,   '0,       8'h31, 32'd9, 1, 1, RES_FULL, 56'd512);
    add_row(REQ_UNSCHED, '0,       8'h20, '0,    1, 1, RES_DONE, 56'd512);  // all copies
    add_row(REQ_UNSCHED, '0,       8'h99, '0,    1, 1, RES_DONE, 56'd512);  // absent id
    add_row(REQ_BOGUS,   TIME_MAX, 8'h5A, '1,    1, 1, RES_DONE, 56'd512);
    add_row(REQ_TICK,    48'd501,  8'h04, '0,    1, 0, RES_DONE, '0);  // burst of fires
    add_row(REQ_TICK,    48'd503,  8'h05, '0,    1, 0, RES_DONE, '0);
    add_row(REQ_TICK,    48'd1,    8'h0B, '0,    1, 0, RES_DONE, '0);  // wall time near zero
    add_row(REQ_TICK,    TIME_MAX, 8'h06, '0,    1, 0, RES_DONE, '0);  // clock saturates
    add_row(REQ_SCHED,   '0,       8'h7E, 32'd5, 1, 1, RES_DONE, CLOCK_MAX);
    add_row(REQ_TICK,    TIME_MAX, 8'h07, '0,    1, 0, RES_DONE, '0);
    add_row(REQ_TICK,    '0,       8'h08, '0,    1, 0, RES_DONE, '0);  // back to not started
    add_row(REQ_TICK,    48'd2000, 8'h09, '0,    1, 0, RES_DONE, '0);  // clock restarts
    add_row(REQ_TICK,    48'd2010, 8'h0A, '0,    1, 0, RES_DONE, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      for (int n = 0; n < plan[i].reps; n++) begin
        send_req(plan[i].req, plan[i].t, plan[i].id, plan[i].dly,
                 plan[i].typed, plan[i].want_status, plan[i].want_now);
      end
    end
    drain();

    // Random phases, each under its own register setting; idle between them.
    jitter_on = 1'b1;
    random_phase(13);
    drain();
    set_config(16'd0, 1'b1);
    jitter_on = 1'b0;
    random_phase(13);
    drain();
    set_config(16'hFFFF, 1'b1);
    jitter_on = 1'b1;
    random_phase(13);
    drain();
    set_config(16'd200, 1'b0);
    random_phase(13);
    drain();
    set_config(16'($urandom_range(1, 65535)), 1'b1);
    jitter_on = 1'b0;
    random_phase(13);
    drain();

    $display("run covered %0d requests and %0d results: %0d fired tasks, %0d table-full",
             n_requests, n_results, n_fired, n_full);
    $display("speeds 256, 0, 200, max and random; clock frozen, running and saturated");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
